// ===== hw/rtl/ddiff_pkg.sv =====
// shared types, constants and calendar tables for the date difference unit
`default_nettype none

package ddiff_pkg;

    // field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 12;
    localparam int COUNT_W  = 20;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // valid year range
    localparam logic [YEAR_W-1:0] MIN_YEAR = 12'd1583;
    localparam logic [YEAR_W-1:0] MAX_YEAR = 12'd2399;

    // year / 100 by reciprocal: (y * 5243) >> 19, exact for any 12-bit year
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // serial day numbers and their difference
    localparam int SERIAL_W = 22;
    localparam int DIFF_W   = SERIAL_W + 1;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 5'd29;
    localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;

    localparam logic signed [DIFF_W-1:0] COUNT_MAX = 23'sd524287;
    localparam logic signed [DIFF_W-1:0] COUNT_MIN = -23'sd524288;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_QUOT,
        ST_A_BASE,
        ST_A_ADD,
        ST_B_QUOT,
        ST_B_BASE,
        ST_B_ADD,
        ST_FINISH
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic sel_b;
        logic calc_quot;
        logic calc_base;
        logic calc_add;
        logic load_out;
    } dp_cmd_t;

    // days in a month of a common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days of a common year before the first of a month
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ddiff_ctrl.sv =====
// sequencing state machine and output handshake for the date difference unit
`default_nettype none

module ddiff_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output ddiff_pkg::dp_cmd_t     cmd
);

    ddiff_pkg::state_t state_reg, state_next;
    logic              out_valid_reg, out_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ddiff_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ddiff_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ddiff_pkg::ST_A_QUOT;
                end
            end
            ddiff_pkg::ST_A_QUOT: begin
                cmd.calc_quot = 1'b1;
                state_next    = ddiff_pkg::ST_A_BASE;
            end
            ddiff_pkg::ST_A_BASE: begin
                cmd.calc_base = 1'b1;
                state_next    = ddiff_pkg::ST_A_ADD;
            end
            ddiff_pkg::ST_A_ADD: begin
                cmd.calc_add = 1'b1;
                state_next   = ddiff_pkg::ST_B_QUOT;
            end
            ddiff_pkg::ST_B_QUOT: begin
                cmd.sel_b     = 1'b1;
                cmd.calc_quot = 1'b1;
                state_next    = ddiff_pkg::ST_B_BASE;
            end
            ddiff_pkg::ST_B_BASE: begin
                cmd.sel_b     = 1'b1;
                cmd.calc_base = 1'b1;
                state_next    = ddiff_pkg::ST_B_ADD;
            end
            ddiff_pkg::ST_B_ADD: begin
                cmd.sel_b    = 1'b1;
                cmd.calc_add = 1'b1;
                state_next   = ddiff_pkg::ST_FINISH;
            end
            ddiff_pkg::ST_FINISH: begin
                // wait for the output register to be free
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ddiff_pkg::ST_IDLE;
                end
            end
            default: state_next = ddiff_pkg::ST_IDLE;
        endcase
    end

    // output item valid
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ddiff_datapath.sv =====
// date registers, serial day arithmetic and result register
`default_nettype none

module ddiff_datapath (
    input  wire logic                                  aclk,
    input  wire ddiff_pkg::dp_cmd_t                    cmd,
    input  wire logic [ddiff_pkg::IN_TDATA_W-1:0]      in_data,
    output logic      [ddiff_pkg::OUT_TDATA_W-1:0]     out_data
);

    // captured dates
    logic [ddiff_pkg::DAY_W-1:0]    day_a_reg, day_b_reg;
    logic [ddiff_pkg::MONTH_W-1:0]  month_a_reg, month_b_reg;
    logic [ddiff_pkg::YEAR_W-1:0]   year_a_reg, year_b_reg;

    // working registers
    logic [ddiff_pkg::QUOT_W-1:0]   quot_reg;
    logic                           leap_reg;
    logic                           ok_a_reg, ok_b_reg;
    logic [ddiff_pkg::SERIAL_W-1:0] serial_a_reg, serial_b_reg;

    // result register
    logic [ddiff_pkg::COUNT_W-1:0]  count_reg;
    logic                           equal_reg, earlier_reg, invalid_reg;

    // date currently worked on
    logic [ddiff_pkg::DAY_W-1:0]    cur_day;
    logic [ddiff_pkg::MONTH_W-1:0]  cur_month;
    logic [ddiff_pkg::YEAR_W-1:0]   cur_year;
    logic [ddiff_pkg::SERIAL_W-1:0] cur_serial;

    assign cur_day    = cmd.sel_b ? day_b_reg    : day_a_reg;
    assign cur_month  = cmd.sel_b ? month_b_reg  : month_a_reg;
    assign cur_year   = cmd.sel_b ? year_b_reg   : year_a_reg;
    assign cur_serial = cmd.sel_b ? serial_b_reg : serial_a_reg;

    // year / 100 by reciprocal multiplication
    logic [ddiff_pkg::PROD_W-1:0] recip_prod;
    logic [ddiff_pkg::QUOT_W-1:0] quot_next;

    assign recip_prod = ddiff_pkg::PROD_W'(cur_year) * ddiff_pkg::PROD_W'(ddiff_pkg::RECIP_100);
    assign quot_next  = recip_prod[ddiff_pkg::RECIP_SHIFT +: ddiff_pkg::QUOT_W];

    // leap year, validity and days before the year
    logic [ddiff_pkg::YEAR_W-1:0]   hundreds;
    logic [ddiff_pkg::YEAR_W-1:0]   rem100;
    logic                           rem_zero;
    logic                           leap;
    logic [ddiff_pkg::YEAR_W-1:0]   prev_year;
    logic [ddiff_pkg::QUOT_W-1:0]   prev_q100;
    logic [ddiff_pkg::DAY_W-1:0]    last_day;
    logic                           date_ok;
    logic [ddiff_pkg::SERIAL_W-1:0] base_serial;

    always_comb begin
        hundreds  = (ddiff_pkg::YEAR_W'(quot_reg) << 6) + (ddiff_pkg::YEAR_W'(quot_reg) << 5)
                  + (ddiff_pkg::YEAR_W'(quot_reg) << 2);
        rem100    = cur_year - hundreds;
        rem_zero  = (rem100 == '0);
        leap      = (cur_year[1:0] == 2'b00) && (!rem_zero || (quot_reg[1:0] == 2'b00));
        prev_year = cur_year - ddiff_pkg::YEAR_W'(1);
        // (y - 1) / 100 drops by one when y is a whole century
        prev_q100 = quot_reg - ddiff_pkg::QUOT_W'(rem_zero);
        last_day  = ((cur_month == ddiff_pkg::MONTH_FEB) && leap) ? ddiff_pkg::FEB_LEAP_DAYS
                                                                 : ddiff_pkg::month_len(cur_month);
        date_ok   = (cur_month >= ddiff_pkg::MONTH_JAN) && (cur_month <= ddiff_pkg::MONTH_DEC)
                  && (cur_year >= ddiff_pkg::MIN_YEAR) && (cur_year <= ddiff_pkg::MAX_YEAR)
                  && (cur_day != '0) && (cur_day <= last_day);
        base_serial = ddiff_pkg::SERIAL_W'(prev_year) * ddiff_pkg::SERIAL_W'(ddiff_pkg::DAYS_PER_YEAR)
                    + ddiff_pkg::SERIAL_W'(prev_year >> 2)
                    - ddiff_pkg::SERIAL_W'(prev_q100)
                    + ddiff_pkg::SERIAL_W'(prev_q100 >> 2);
    end

    // add the month and day within the year
    logic [ddiff_pkg::SERIAL_W-1:0] full_serial;

    assign full_serial = cur_serial
                       + ddiff_pkg::SERIAL_W'(ddiff_pkg::days_before(cur_month))
                       + ddiff_pkg::SERIAL_W'((cur_month > ddiff_pkg::MONTH_FEB) && leap_reg)
                       + ddiff_pkg::SERIAL_W'(cur_day);

    // difference, flags and saturation
    logic signed [ddiff_pkg::DIFF_W-1:0]  diff;
    logic                                 invalid;
    logic [ddiff_pkg::COUNT_W-1:0]        count_next;
    logic                                 equal_next, earlier_next;

    always_comb begin
        diff    = $signed({1'b0, serial_b_reg}) - $signed({1'b0, serial_a_reg});
        invalid = !(ok_a_reg && ok_b_reg);
        if (invalid) begin
            count_next   = '0;
            equal_next   = 1'b0;
            earlier_next = 1'b0;
        end else begin
            equal_next   = (diff == '0);
            // positive: sign bit clear and not zero
            earlier_next = !diff[ddiff_pkg::DIFF_W-1] && (diff != '0);
            if (diff > ddiff_pkg::COUNT_MAX) begin
                count_next = ddiff_pkg::COUNT_MAX[ddiff_pkg::COUNT_W-1:0];
            end else if (diff < ddiff_pkg::COUNT_MIN) begin
                count_next = ddiff_pkg::COUNT_MIN[ddiff_pkg::COUNT_W-1:0];
            end else begin
                count_next = diff[ddiff_pkg::COUNT_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            day_a_reg   <= in_data[4:0];
            month_a_reg <= in_data[8:5];
            year_a_reg  <= in_data[20:9];
            day_b_reg   <= in_data[25:21];
            month_b_reg <= in_data[29:26];
            year_b_reg  <= in_data[41:30];
        end
        if (cmd.calc_quot) begin
            quot_reg <= quot_next;
        end
        if (cmd.calc_base) begin
            leap_reg <= leap;
            if (cmd.sel_b) begin
                ok_b_reg     <= date_ok;
                serial_b_reg <= base_serial;
            end else begin
                ok_a_reg     <= date_ok;
                serial_a_reg <= base_serial;
            end
        end
        if (cmd.calc_add) begin
            if (cmd.sel_b) begin
                serial_b_reg <= full_serial;
            end else begin
                serial_a_reg <= full_serial;
            end
        end
        if (cmd.load_out) begin
            count_reg   <= count_next;
            equal_reg   <= equal_next;
            earlier_reg <= earlier_next;
            invalid_reg <= invalid;
        end
    end

    assign out_data = {1'b0, invalid_reg, earlier_reg, equal_reg, count_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/date_difference_in_days_unit.sv =====
// top level of the Gregorian date difference unit
//
//  channel | direction | handshake          | tdata fields (low bit first)
//  s_      | in        | s_tvalid/s_tready  | day_a, month_a, year_a, day_b, month_b, year_b
//  m_      | out       | m_tvalid/m_tready  | day_count, dates_equal, first_is_earlier,
//          |           |                    | date_invalid
//
// once an item is accepted, the sequencer runs three steps of the shared serial
// day unit (quotient, year base, month/day add) for each date, then forms the difference
// and loads it into the result register, raising m_tvalid; it then returns to idle.
// a new item is accepted only while the sequencer is idle; the result register lets it
// start while the previous result still waits on m_tready, and the difference step
// holds until that result is taken.
// aresetn is synchronous and active low; it clears the sequencer and the output valid.
`default_nettype none

module date_difference_in_days_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // day_a[4:0], month_a[8:5], year_a[20:9], day_b[25:21], month_b[29:26], year_b[41:30]
    input  wire logic [ddiff_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // day_count[19:0], dates_equal[20], first_is_earlier[21], date_invalid[22]
    output logic      [ddiff_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    ddiff_pkg::dp_cmd_t cmd;

    // sequencer
    ddiff_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // arithmetic and storage
    ddiff_datapath u_datapath (
        .aclk     (aclk),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking stream testbench for the date difference unit
`timescale 1ns / 100ps

module testbench;

    localparam int DAY_W     = ddiff_pkg::DAY_W;
    localparam int MONTH_W   = ddiff_pkg::MONTH_W;
    localparam int YEAR_W    = ddiff_pkg::YEAR_W;
    localparam int COUNT_W   = ddiff_pkg::COUNT_W;
    localparam int IN_W      = ddiff_pkg::IN_TDATA_W;
    localparam int OUT_W     = ddiff_pkg::OUT_TDATA_W;
    localparam int PAIR_BITS = 2 * (DAY_W + MONTH_W + YEAR_W);

    localparam int DAY_COUNT_HI = (1 << (COUNT_W - 1)) - 1;
    localparam int DAY_COUNT_LO = -(1 << (COUNT_W - 1));

    // idling phases
    localparam int PH_SLOW_RX = 0;
    localparam int PH_SLOW_TX = 1;
    localparam int PH_NO_IDLE = 2;

    // receiver hold-off
    localparam int HOLD_CYCLES = 60;
    localparam int HOLD_AT_1   = 30;
    localparam int HOLD_AT_2   = 95;

    localparam int RANDOM_PER_PHASE = 26;
    localparam int SETTLE_CYCLES    = 20;

    typedef struct {
        logic [DAY_W-1:0]   day_a;
        logic [MONTH_W-1:0] month_a;
        logic [YEAR_W-1:0]  year_a;
        logic [DAY_W-1:0]   day_b;
        logic [MONTH_W-1:0] month_b;
        logic [YEAR_W-1:0]  year_b;
        int                 phase;
        bit                 drain_first;
    } date_pair_t;

    typedef struct {
        logic signed [COUNT_W-1:0] day_count;
        logic                      dates_equal;
        logic                      first_is_earlier;
        logic                      date_invalid;
    } day_diff_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // day_a, month_a, year_a, day_b, month_b, year_b
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // day_count, dates_equal, first_is_earlier, date_invalid
    logic [OUT_W-1:0] m_tdata;

    date_pair_t date_pairs_to_send[$];
    day_diff_t  expected_diffs[$];
    date_pair_t item_on_bus;
    date_pair_t head;
    int         send_phase = PH_SLOW_RX;
    int         send_gap;
    bit         offer;
    int         n_errors = 0;
    int         results_seen = 0;
    int         hold_left = 0;
    day_diff_t  want;

    date_difference_in_days_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock and reset
    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // calendar arithmetic
    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_days(input int m, input int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_valid(input int d, input int m, input int y);
        return m >= 1 && m <= 12 && y >= int'(ddiff_pkg::MIN_YEAR)
            && y <= int'(ddiff_pkg::MAX_YEAR) && d >= 1 && d <= month_days(m, y);
    endfunction

    // days since the start of the proleptic calendar, for a valid date
    function automatic int day_number(input int d, input int m, input int y);
        int p;
        int n;
        p = y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400;
        for (int k = 1; k < m; k++)
            n += month_days(k, y);
        return n + d;
    endfunction

    function automatic day_diff_t predict_day_diff(input date_pair_t p);
        day_diff_t r;
        int        diff;
        r.day_count        = '0;
        r.dates_equal      = 1'b0;
        r.first_is_earlier = 1'b0;
        r.date_invalid     = 1'b0;
        if (!date_valid(p.day_a, p.month_a, p.year_a)
            || !date_valid(p.day_b, p.month_b, p.year_b)) begin
            r.date_invalid = 1'b1;
        end else begin
            diff = day_number(p.day_b, p.month_b, p.year_b)
                 - day_number(p.day_a, p.month_a, p.year_a);
            r.dates_equal      = (diff == 0);
            r.first_is_earlier = (diff > 0);
            if (diff > DAY_COUNT_HI) diff = DAY_COUNT_HI;
            if (diff < DAY_COUNT_LO) diff = DAY_COUNT_LO;
            r.day_count = diff[COUNT_W-1:0];
        end
        return r;
    endfunction

    // stimulus queue helpers
    task automatic add_pair(input int da, input int ma, input int ya,
                            input int db, input int mb, input int yb,
                            input int phase, input bit drain_first);
        date_pair_t p;
        p.day_a       = da[DAY_W-1:0];
        p.month_a     = ma[MONTH_W-1:0];
        p.year_a      = ya[YEAR_W-1:0];
        p.day_b       = db[DAY_W-1:0];
        p.month_b     = mb[MONTH_W-1:0];
        p.year_b      = yb[YEAR_W-1:0];
        p.phase       = phase;
        p.drain_first = drain_first;
        date_pairs_to_send.push_back(p);
    endtask

    task automatic pick_valid_date(output int d, output int m, output int y);
        case ($urandom_range(9))
            0:       y = ddiff_pkg::MIN_YEAR;
            1:       y = ddiff_pkg::MAX_YEAR;
            default: y = $urandom_range(ddiff_pkg::MAX_YEAR, ddiff_pkg::MIN_YEAR);
        endcase
        m = $urandom_range(12, 1);
        d = $urandom_range(month_days(m, y), 1);
    endtask

    // driver: offers queued items and records their predictions on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                expected_diffs.push_back(predict_day_diff(item_on_bus));
            if (!s_tvalid || s_tready) begin
                offer = 1'b0;
                if (date_pairs_to_send.size() != 0) begin
                    head     = date_pairs_to_send[0];
                    send_gap = (head.phase == PH_SLOW_RX) ? 15 :
                               (head.phase == PH_SLOW_TX) ? 87 : 0;
                    offer    = !(head.drain_first && expected_diffs.size() != 0)
                               && ($urandom_range(99) >= send_gap);
                end
                if (offer) begin
                    item_on_bus = date_pairs_to_send.pop_front();
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {{(IN_W - PAIR_BITS){1'b0}},
                                   item_on_bus.year_b, item_on_bus.month_b,
                                   item_on_bus.day_b, item_on_bus.year_a,
                                   item_on_bus.month_a, item_on_bus.day_a};
                    send_phase <= item_on_bus.phase;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result item against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_diffs.size() == 0) begin
                    $error("result item with no prediction waiting: tdata %h", m_tdata);
                    n_errors++;
                end else begin
                    want = expected_diffs.pop_front();
                    if ($signed(m_tdata[COUNT_W-1:0]) !== want.day_count) begin
                        $error("day_count: expected %0d, got %0d", want.day_count,
                               $signed(m_tdata[COUNT_W-1:0]));
                        n_errors++;
                    end
                    if (m_tdata[COUNT_W] !== want.dates_equal) begin
                        $error("dates_equal: expected %0b, got %0b", want.dates_equal,
                               m_tdata[COUNT_W]);
                        n_errors++;
                    end
                    if (m_tdata[COUNT_W+1] !== want.first_is_earlier) begin
                        $error("first_is_earlier: expected %0b, got %0b",
                               want.first_is_earlier, m_tdata[COUNT_W+1]);
                        n_errors++;
                    end
                    if (m_tdata[COUNT_W+2] !== want.date_invalid) begin
                        $error("date_invalid: expected %0b, got %0b", want.date_invalid,
                               m_tdata[COUNT_W+2]);
                        n_errors++;
                    end
                end
                results_seen++;
                if (results_seen == HOLD_AT_1 || results_seen == HOLD_AT_2)
                    hold_left = HOLD_CYCLES;
            end
            // long hold-off lets the unit fill up and stall its input
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= ((send_phase == PH_SLOW_RX) ? 87 :
                             (send_phase == PH_SLOW_TX) ? 15 : 0));
            end
        end
    end

    // stimulus and end of run
    initial begin
        int da, ma, ya, db, mb, yb;
        int pick;

        // directed: equality, range extremes, leap rules, invalid fields
        add_pair(29, 2, 2000, 29, 2, 2000, PH_SLOW_RX, 0);
        add_pair(1, 1, 1583, 31, 12, 2399, PH_SLOW_RX, 0);
        add_pair(31, 12, 2399, 1, 1, 1583, PH_SLOW_RX, 0);
        add_pair(29, 2, 2000, 1, 3, 2000, PH_SLOW_RX, 0);
        add_pair(28, 2, 1900, 1, 3, 1900, PH_SLOW_RX, 0);
        add_pair(29, 2, 1900, 1, 3, 1900, PH_SLOW_RX, 0);
        add_pair(1, 1, 2004, 29, 2, 2004, PH_SLOW_RX, 0);
        add_pair(29, 2, 2100, 1, 1, 2000, PH_SLOW_RX, 0);
        add_pair(1, 1, 2000, 29, 2, 2003, PH_SLOW_RX, 0);
        add_pair(31, 12, 1999, 1, 1, 2000, PH_SLOW_RX, 0);
        add_pair(0, 5, 2010, 1, 5, 2010, PH_SLOW_RX, 0);
        add_pair(1, 4, 2010, 31, 4, 2010, PH_SLOW_RX, 0);
        add_pair(1, 0, 2010, 1, 1, 2010, PH_SLOW_RX, 0);
        add_pair(1, 1, 2010, 1, 13, 2010, PH_SLOW_RX, 0);
        add_pair(31, 15, 4095, 31, 15, 4095, PH_SLOW_RX, 0);
        add_pair(1, 1, 1582, 1, 1, 1583, PH_SLOW_RX, 0);
        add_pair(31, 12, 2399, 1, 1, 2400, PH_SLOW_RX, 0);
        add_pair(0, 0, 0, 0, 0, 0, PH_SLOW_RX, 0);
        add_pair(15, 6, 1800, 14, 6, 1800, PH_SLOW_RX, 0);
        add_pair(31, 1, 2399, 31, 12, 2399, PH_SLOW_RX, 0);
        add_pair(1, 3, 2400, 1, 3, 2000, PH_SLOW_RX, 0);
        add_pair(10, 10, 2048, 10, 10, 2047, PH_SLOW_RX, 0);

        // random: mostly valid pairs, some broken fields and raw noise
        for (int ph = PH_SLOW_RX; ph <= PH_NO_IDLE; ph++) begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick_valid_date(da, ma, ya);
                pick = $urandom_range(99);
                if (pick < 15) begin
                    db = da; mb = ma; yb = ya;
                end else if (pick < 35) begin
                    yb = ya;
                    mb = $urandom_range(12, 1);
                    db = $urandom_range(month_days(mb, yb), 1);
                end else begin
                    pick_valid_date(db, mb, yb);
                end
                if (pick >= 65 && pick < 85) begin
                    case ($urandom_range(3))
                        0: da = ($urandom_range(1)) ? 0 : month_days(ma, ya) + 1;
                        1: mb = ($urandom_range(1)) ? 0 : $urandom_range(15, 13);
                        2: ya = $urandom_range(ddiff_pkg::MIN_YEAR - 1, 0);
                        default: yb = $urandom_range(4095, ddiff_pkg::MAX_YEAR + 1);
                    endcase
                end else if (pick >= 85) begin
                    da = $urandom_range(31); ma = $urandom_range(15);
                    ya = $urandom_range(4095);
                    db = $urandom_range(31); mb = $urandom_range(15);
                    yb = $urandom_range(4095);
                end
                add_pair(da, ma, ya, db, mb, yb, ph, (n == 0) && (ph != PH_SLOW_RX));
            end
        end

        @(posedge aclk);
        while (!aresetn || date_pairs_to_send.size() != 0 || s_tvalid
               || expected_diffs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (expected_diffs.size() != 0) begin
            $error("%0d predicted result items never arrived", expected_diffs.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("PASS date_difference_in_days_unit");
        end else begin
            $display("FAIL date_difference_in_days_unit");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("FAIL date_difference_in_days_unit");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ddiff_pkg.sv
hw/rtl/ddiff_ctrl.sv
hw/rtl/ddiff_datapath.sv
hw/rtl/date_difference_in_days_unit.sv
tb/sv/testbench.sv
